### hdl/mds_pkg.sv
package mds_pkg;

   localparam int DATA_W = 32;
   localparam int SIDE_CSR_W = 4;

   // Controller states, one-hot.
   typedef enum logic [6:0] {
      ST_LOAD     = 7'b0000001,
      ST_DIAG     = 7'b0000010,
      ST_CUR      = 7'b0000100,
      ST_CMP      = 7'b0001000,
      ST_WBP      = 7'b0010000,
      ST_EMIT_RD  = 7'b0100000,
      ST_EMIT_OUT = 7'b1000000
   } mds_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mem_we;
      logic wr_src_cur;
      logic rd_en;
      logic cur_load;
      logic cmp_en;
      logic out_load;
      logic out_last;
   } mds_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } mds_status_type;

endpackage

### hdl/matrix_diagonal_sorter.sv
// Channel   Direction  Handshake           Payload
// req_      in         req_valid/stall     req_element_value (signed Q16.16)
// rsp_      out        rsp_valid/stall     rsp_sorted_value, rsp_last_of_matrix
// csr_      in         csr_valid/ready     csr_matrix_side (4 bits)
//
// Loading accepts n*n elements; req_stall stays high from then on until the final result
// has moved into the output register. The sort opens each diagonal, then for each position
// loads it as the running minimum, compares that with each later element and writes the
// minimum back. Emission first reads element 0, then moves one element per cycle into the
// output register while the result side does not stall.
// Reset is synchronous and returns the side to its default and empties the loader.

module matrix_diagonal_sorter #(
   parameter int MAX_SIDE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [mds_pkg::DATA_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [mds_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_last_of_matrix,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mds_pkg::SIDE_CSR_W-1:0]    csr_matrix_side
);

   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int AW         = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SW         = $clog2(MAX_SIDE + 1);
   localparam int RESET_SIDE = (8 > MAX_SIDE) ? MAX_SIDE : 8;

   // The side register holds the side already clamped into the range 1 to MAX_SIDE,
   // together with the element count of a full matrix, so the loop logic never has to
   // deal with a side of zero or an oversized side.
   logic [SW-1:0]    side_ff, side_in;
   logic [CNT_W-1:0] total_ff, total_in;

   mds_pkg::mds_cmd_type    cmd;
   mds_pkg::mds_status_type status;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;

   // The register is always ready, so a write transaction is never held off.
   assign csr_ready = 1'b1;

   always_comb begin
      side_in  = side_ff;
      total_in = total_ff;
      if (csr_valid && csr_ready) begin
         if (csr_matrix_side == '0) begin
            side_in = SW'(1);
         end else if (csr_matrix_side > mds_pkg::SIDE_CSR_W'(MAX_SIDE)) begin
            side_in = SW'(MAX_SIDE);
         end else begin
            side_in = SW'(csr_matrix_side);
         end
         total_in = CNT_W'(side_in) * CNT_W'(side_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SW'(RESET_SIDE);
         total_ff <= CNT_W'(RESET_SIDE * RESET_SIDE);
      end else begin
         side_ff  <= side_in;
         total_ff <= total_in;
      end
   end

   // The controller sequences load, sort and emit; the datapath holds the element
   // memory, the running minimum of the sort and the result register.
   mds_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .side      (side_ff),
      .total     (total_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   mds_dpath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .rd_addr            (rd_addr),
      .wr_addr            (wr_addr),
      .req_element_value  (req_element_value),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_sorted_value   (rsp_sorted_value),
      .rsp_last_of_matrix (rsp_last_of_matrix),
      .status             (status)
   );

endmodule

### hdl/mds_dpath.sv
module mds_dpath #(
   parameter int MAX_SIDE = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mds_pkg::mds_cmd_type                cmd,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] rd_addr,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] wr_addr,
   input  logic signed [mds_pkg::DATA_W-1:0]   req_element_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [mds_pkg::DATA_W-1:0]   rsp_sorted_value,
   output logic                                rsp_last_of_matrix,
   output mds_pkg::mds_status_type             status
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;

   logic signed [mds_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [mds_pkg::DATA_W-1:0] rdata_ff;
   logic signed [mds_pkg::DATA_W-1:0] cur_ff;
   logic signed [mds_pkg::DATA_W-1:0] cur_in;
   logic signed [mds_pkg::DATA_W-1:0] wdata;
   logic signed [mds_pkg::DATA_W-1:0] out_value_ff;
   logic                              out_last_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic                              swap;
   logic                              we;

   // The running minimum moves into the entry it is compared against when it is larger.
   assign swap  = cmd.cmp_en && (cur_ff > rdata_ff);
   assign we    = cmd.mem_we || swap;
   assign wdata = cmd.wr_src_cur ? cur_ff : req_element_value;

   always_comb begin
      cur_in = cur_ff;
      if (cmd.cur_load || swap) begin
         cur_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign status.out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= rdata_ff;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_sorted_value   = out_value_ff;
   assign rsp_last_of_matrix = out_last_ff;

endmodule

### hdl/mds_ctrl.sv
module mds_ctrl #(
   parameter int MAX_SIDE = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [$clog2(MAX_SIDE+1)-1:0]             side,
   input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]    total,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  mds_pkg::mds_status_type                  status,
   output mds_pkg::mds_cmd_type                     cmd,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      rd_addr,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      wr_addr
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int CW    = $clog2(MAX_SIDE);

   mds_pkg::mds_state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_next;
   logic [CW-1:0]    k_ff, k_in;
   logic             lower_ff, lower_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [CW-1:0]    p_row_ff, p_row_in, p_col_ff, p_col_in;
   logic [AW-1:0]    p_addr_ff, p_addr_in;
   logic [CW-1:0]    q_row_ff, q_row_in, q_col_ff, q_col_in;
   logic [AW-1:0]    q_addr_ff, q_addr_in;
   logic [AW-1:0]    step;
   logic [CW-1:0]    start_row, start_col;
   logic [AW-1:0]    start_addr;
   logic             diag_live, p_more, q_more;

   assign step     = AW'(side) + AW'(1);
   assign cnt_next = cnt_ff + CNT_W'(1);

   assign start_row  = lower_ff ? k_ff : CW'(0);
   assign start_col  = lower_ff ? CW'(0) : k_ff;
   assign start_addr = lower_ff ? base_ff : AW'(k_ff);

   // A diagonal starting at offset k has more than one element while k + 1 < n.
   assign diag_live = (SW'(k_ff) + SW'(1)) < side;
   assign p_more    = ((SW'(p_row_ff) + SW'(2)) < side) && ((SW'(p_col_ff) + SW'(2)) < side);
   assign q_more    = ((SW'(q_row_ff) + SW'(1)) < side) && ((SW'(q_col_ff) + SW'(1)) < side);

   assign req_stall = (state_ff != mds_pkg::ST_LOAD);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      lower_in  = lower_ff;
      base_in   = base_ff;
      p_row_in  = p_row_ff;
      p_col_in  = p_col_ff;
      p_addr_in = p_addr_ff;
      q_row_in  = q_row_ff;
      q_col_in  = q_col_ff;
      q_addr_in = q_addr_ff;
      cmd       = '0;
      rd_addr   = q_addr_ff;
      wr_addr   = q_addr_ff;

      case (state_ff)
         mds_pkg::ST_LOAD: begin
            wr_addr = cnt_ff[AW-1:0];
            if (req_valid) begin
               cmd.mem_we = 1'b1;
               if (cnt_next >= total) begin
                  cnt_in   = '0;
                  k_in     = '0;
                  lower_in = 1'b0;
                  base_in  = '0;
                  state_in = mds_pkg::ST_DIAG;
               end else begin
                  cnt_in = cnt_next;
               end
            end
         end

         mds_pkg::ST_DIAG: begin
            if (diag_live) begin
               rd_addr    = start_addr;
               cmd.rd_en  = 1'b1;
               p_row_in   = start_row;
               p_col_in   = start_col;
               p_addr_in  = start_addr;
               q_row_in   = start_row + CW'(1);
               q_col_in   = start_col + CW'(1);
               q_addr_in  = start_addr + step;
               state_in   = mds_pkg::ST_CUR;
            end else begin
               state_in = mds_pkg::ST_EMIT_RD;
            end
         end

         mds_pkg::ST_CUR: begin
            cmd.cur_load = 1'b1;
            cmd.rd_en    = 1'b1;
            rd_addr      = q_addr_ff;
            state_in     = mds_pkg::ST_CMP;
         end

         mds_pkg::ST_CMP: begin
            cmd.cmp_en     = 1'b1;
            cmd.wr_src_cur = 1'b1;
            wr_addr        = q_addr_ff;
            rd_addr        = q_addr_ff + step;
            if (q_more) begin
               cmd.rd_en = 1'b1;
               q_row_in  = q_row_ff + CW'(1);
               q_col_in  = q_col_ff + CW'(1);
               q_addr_in = q_addr_ff + step;
            end else begin
               state_in = mds_pkg::ST_WBP;
            end
         end

         mds_pkg::ST_WBP: begin
            cmd.mem_we     = 1'b1;
            cmd.wr_src_cur = 1'b1;
            wr_addr        = p_addr_ff;
            rd_addr        = p_addr_ff + step;
            if (p_more) begin
               cmd.rd_en = 1'b1;
               p_row_in  = p_row_ff + CW'(1);
               p_col_in  = p_col_ff + CW'(1);
               p_addr_in = p_addr_ff + step;
               q_row_in  = p_row_ff + CW'(2);
               q_col_in  = p_col_ff + CW'(2);
               q_addr_in = p_addr_ff + step + step;
               state_in  = mds_pkg::ST_CUR;
            end else begin
               if (!lower_ff && (k_ff != '0)) begin
                  lower_in = 1'b1;
               end else begin
                  lower_in = 1'b0;
                  k_in     = k_ff + CW'(1);
                  base_in  = base_ff + AW'(side);
               end
               state_in = mds_pkg::ST_DIAG;
            end
         end

         mds_pkg::ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = cnt_ff[AW-1:0];
            state_in  = mds_pkg::ST_EMIT_OUT;
         end

         mds_pkg::ST_EMIT_OUT: begin
            rd_addr = cnt_next[AW-1:0];
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (cnt_next == total);
               if (cnt_next == total) begin
                  cnt_in   = '0;
                  state_in = mds_pkg::ST_LOAD;
               end else begin
                  cmd.rd_en = 1'b1;
                  cnt_in    = cnt_next;
               end
            end
         end

         default: begin
            state_in = mds_pkg::ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mds_pkg::ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      lower_ff  <= lower_in;
      base_ff   <= base_in;
      p_row_ff  <= p_row_in;
      p_col_ff  <= p_col_in;
      p_addr_ff <= p_addr_in;
      q_row_ff  <= q_row_in;
      q_col_ff  <= q_col_in;
      q_addr_ff <= q_addr_in;
   end

endmodule

### bench/matrix_diagonal_sorter_tb.sv
module matrix_diagonal_sorter_tb;

   localparam int MAX_SIDE    = 8;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   // Cycles to let pass after the last result before the side register is touched.
   localparam int SETTLE      = 400;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES = 300;
   // Cycles without any transaction on any channel before the run is declared hung.
   localparam int QUIET_LIMIT = 4000;

   // One element of a sorted matrix as it should leave the block.
   typedef struct packed {
      logic signed [mds_pkg::DATA_W-1:0] value;
      logic                              last;
   } sorted_item_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [mds_pkg::DATA_W-1:0] req_element_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [mds_pkg::DATA_W-1:0] rsp_sorted_value;
   logic                              rsp_last_of_matrix;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [mds_pkg::SIDE_CSR_W-1:0]    csr_matrix_side = '0;

   // Elements waiting to be offered on the request channel, and the sorted elements
   // the block still owes us, oldest first.
   logic signed [mds_pkg::DATA_W-1:0] element_feed[$];
   sorted_item_type                   sorted_elements[$];

   // Our own copy of the block's element store, fill level and side register.
   logic signed [mds_pkg::DATA_W-1:0] mirror_store [STORE_DEPTH];
   logic [6:0]                        mirror_count = '0;
   logic [mds_pkg::SIDE_CSR_W-1:0]    mirror_side = 4'd8;

   int items_offered = 0;
   int items_taken   = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;
   int holds_wanted  = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   // While steady is set neither side idles, which gives one long stretch at full rate.
   logic steady = 1'b0;

   matrix_diagonal_sorter #(
      .MAX_SIDE(MAX_SIDE)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_value   (rsp_sorted_value),
      .rsp_last_of_matrix (rsp_last_of_matrix),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_matrix_side    (csr_matrix_side)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Store one accepted element. When it completes a matrix at the side now in force,
   // sort every diagonal of the first n*n stored elements and queue the whole matrix
   // in row-major order, the final element flagged.
   task automatic take_element(input logic signed [mds_pkg::DATA_W-1:0] v);
      int n, total, d, i, j, i1, j1, p, q;
      logic signed [mds_pkg::DATA_W-1:0] t;
      sorted_item_type item;
      n = (mirror_side == 0) ? 1 : ((mirror_side > MAX_SIDE) ? MAX_SIDE : int'(mirror_side));
      total = n * n;
      mirror_store[mirror_count % STORE_DEPTH] = v;
      mirror_count = mirror_count + 7'd1;
      if (int'(mirror_count) >= total) begin
         // Diagonals are independent, so they can be walked in any order. A diagonal
         // with offset d starts at row -d for d < 0 and at column d otherwise.
         for (d = 1 - n; d < n; d++) begin
            i = (d < 0) ? -d : 0;
            j = (d > 0) ? d : 0;
            while (i + 1 < n && j + 1 < n) begin
               i1 = i + 1;
               j1 = j + 1;
               while (i1 < n && j1 < n) begin
                  p = (i * n + j) % STORE_DEPTH;
                  q = (i1 * n + j1) % STORE_DEPTH;
                  if (mirror_store[p] > mirror_store[q]) begin
                     t = mirror_store[p];
                     mirror_store[p] = mirror_store[q];
                     mirror_store[q] = t;
                  end
                  i1 = i1 + 1;
                  j1 = j1 + 1;
               end
               i = i + 1;
               j = j + 1;
            end
         end
         for (i = 0; i < total; i++) begin
            item.value = mirror_store[i % STORE_DEPTH];
            item.last  = (i + 1 == total);
            sorted_elements.push_back(item);
         end
         mirror_count = '0;
      end
   endtask

   // Driver. A new element is put up only once the previous transaction has gone
   // through, so a stalled payload never changes and valid never looks at stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (element_feed.size() > 0 && (steady || $urandom_range(0, 99) >= 32)) begin
            req_valid         <= 1'b1;
            req_element_value <= element_feed.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Normally it stalls at random; when a hold-off is asked for, it keeps
   // stall high for a long count of its own so that the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_wanted) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 32);
      end
   end

   // Monitor. Every transaction on every channel is seen here at the edge where it
   // happens, so the mirror state advances in the same order as the block's.
   always @(posedge clock) begin : monitor
      sorted_item_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            mirror_side = csr_matrix_side;
         end
         if (req_valid && !req_stall) begin
            items_taken = items_taken + 1;
            take_element(req_element_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_elements.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result: value %h last %b",
                           rsp_sorted_value, rsp_last_of_matrix);
               end
               mismatches = mismatches + 1;
            end else begin
               want = sorted_elements.pop_front();
               if (rsp_sorted_value !== want.value || rsp_last_of_matrix !== want.last) begin
                  if (mismatches < 10) begin
                     $display("mismatch: expected value %h last %b, got value %h last %b",
                              want.value, want.last, rsp_sorted_value, rsp_last_of_matrix);
                  end
                  mismatches = mismatches + 1;
               end
            end
         end
      end
   end

   // Watchdog. A correct block never goes this long without some transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic signed [mds_pkg::DATA_W-1:0] v);
      element_feed.push_back(v);
      items_offered = items_offered + 1;
   endtask

   // Half full-range values; small values give ties and sign changes near zero,
   // and the two extremes show up regularly.
   function automatic logic signed [mds_pkg::DATA_W-1:0] rand_element();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom;
      if (pick < 8) return ($urandom_range(0, 6) - 3) * 65536;
      if (pick == 8) return 32'sh7FFF_FFFF;
      return 32'sh8000_0000;
   endfunction

   // Waits until every offered element has been taken and every owed result has come.
   task automatic wait_drained();
      do @(negedge clock); while (items_taken != items_offered || sorted_elements.size() != 0);
   endtask

   // Drains, lets the block settle, then writes the side register in one transaction.
   task automatic write_side(input logic [mds_pkg::SIDE_CSR_W-1:0] s);
      wait_drained();
      repeat (SETTLE) @(negedge clock);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_matrix_side <= s;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int k, m, phase, side, eff;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Side 1: a single element is its own sorted matrix, at both extremes.
      write_side(4'd1);
      offer(32'sh7FFF_FFFF);
      offer(32'sh8000_0000);
      // A side of zero behaves as side 1.
      write_side(4'd0);
      offer(32'sh0001_0000);
      // Side 2 with the extremes, so the signed comparison is tested at its limits.
      write_side(4'd2);
      offer(32'sh7FFF_FFFF);
      offer(32'sh8000_0000);
      offer(-32'sd1);
      offer(32'sd0);
      // Side 3 in descending order through zero: every diagonal must be reversed.
      write_side(4'd3);
      for (k = 0; k < 9; k++) offer((4 - k) * 65536);
      // Side lowered during a load: three elements at side 3, then side 2, and the
      // next element completes a 2x2 matrix from the first four stored.
      wait_drained();
      offer(5 * 65536);
      offer(-5 * 65536);
      offer(32'sd0);
      write_side(4'd2);
      offer(32'sh0000_8000);
      // Fill level already past the new size: two elements at side 2, then side 1,
      // and the third element sends out only the first stored element.
      wait_drained();
      offer(32'sh1234_5678);
      offer(-32'sh0765_4321);
      write_side(4'd1);
      offer(32'sh0000_0001);

      // A long stretch at full rate on both sides.
      write_side(4'd2);
      steady = 1'b1;
      for (m = 0; m < 3; m++) begin
         for (k = 0; k < 4; k++) offer(rand_element());
      end
      wait_drained();
      steady = 1'b0;

      // Receiver holds off while two matrices are offered, so emission stalls and
      // the block refuses further input until the hold-off ends.
      holds_wanted = holds_wanted + 1;
      for (m = 0; m < 2; m++) begin
         for (k = 0; k < 4; k++) offer(rand_element());
      end

      // Largest matrix, once at the nominal maximum.
      write_side(4'd8);
      for (k = 0; k < 64; k++) offer(rand_element());

      // An over-range side acts as the maximum; break the load off partway and drop
      // the side, so the next element completes a 2x2 matrix from the stored prefix.
      write_side(4'd15);
      for (k = 0; k < 6; k++) offer(rand_element());
      write_side(4'd2);
      offer(rand_element());

      // Random small sides, one matrix with random content each, occasional sender
      // pauses until all results are in, and now and then a broken-off partial load.
      for (phase = 0; phase < 2; phase++) begin
         side = $urandom_range(0, 3);
         eff  = (side == 0) ? 1 : side;
         write_side(side[mds_pkg::SIDE_CSR_W-1:0]);
         if ($urandom_range(0, 3) == 0) wait_drained();
         for (k = 0; k < eff * eff; k++) offer(rand_element());
         if (eff > 1 && $urandom_range(0, 2) == 0) begin
            for (k = $urandom_range(1, eff * eff - 1); k > 0; k--) offer(rand_element());
         end
      end

      wait_drained();
      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### matrix_diagonal_sorter.f
hdl/mds_pkg.sv
hdl/mds_dpath.sv
hdl/mds_ctrl.sv
hdl/matrix_diagonal_sorter.sv
bench/matrix_diagonal_sorter_tb.sv
